FILE: design/assert_macros.svh
// Assertion macros used by the checker file of the k-mer bucket index builder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/kbib_pkg.sv
// Shared types, sizes and codes for the k-mer bucket index builder.
// No dependencies; used by every module of the block.
package kbib_pkg;

  // sizing
  localparam int KMER_BITS       = 12;
  localparam int STORE_ADDR_BITS = 16;
  localparam int OFFSET_BITS     = 32;
  localparam int NUM_BINS        = 1 << KMER_BITS;
  localparam int STORE_SIZE      = 1 << STORE_ADDR_BITS;
  localparam int COUNT_W         = STORE_ADDR_BITS + 1;

  // stream field widths
  localparam int CMD_W     = 2;
  localparam int KMER_ID_W = 12;
  localparam int OFFSET_W  = 32;
  localparam int ENTRY_W   = 16;
  localparam int STATUS_W  = 3;
  localparam int MCOUNT_W  = 17;
  localparam int BASE_W    = 16;
  localparam int VALUE_W   = 32;

  // tdata layout, first field in the low bits
  localparam int IN_FIELDS_W = KMER_ID_W + OFFSET_W + ENTRY_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int ID_LSB      = 0;
  localparam int OFF_LSB     = ID_LSB + KMER_ID_W;
  localparam int IDX_LSB     = OFF_LSB + OFFSET_W;

  localparam int OUT_FIELDS_W = MCOUNT_W + BASE_W + VALUE_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  // compare width for entry index against the running total
  localparam int CMP_W = (ENTRY_W > COUNT_W) ? ENTRY_W : COUNT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_COUNT = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_OVERFLOW   = 3'd1,
    ST_BIN_FULL   = 3'd2,
    ST_COUNT_LATE = 3'd3,
    ST_PENDING    = 3'd4,
    ST_RANGE      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LAYOUT,
    S_REREAD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic clear;
    logic layout;
    logic exec;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic layout_last;
    logic layout_done;
    logic in_is_add;
    logic out_busy;
  } ctrl_stat_t;

endpackage

FILE: design/kbib_ctrl.sv
// Sequencer for the k-mer bucket index builder: clear sweep, accept, layout, execute.
// Depends on kbib_pkg.
module kbib_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  kbib_pkg::ctrl_stat_t stat,
  output kbib_pkg::ctrl_cmd_t  cmd
);

  kbib_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kbib_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      kbib_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) state_next = kbib_pkg::S_IDLE;
      end
      kbib_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          // first add triggers the prefix-sum pass
          if (stat.in_is_add && !stat.layout_done) state_next = kbib_pkg::S_LAYOUT;
          else state_next = kbib_pkg::S_EXEC;
        end
      end
      kbib_pkg::S_LAYOUT: begin
        cmd.layout = 1'b1;
        if (stat.layout_last) state_next = kbib_pkg::S_REREAD;
      end
      kbib_pkg::S_REREAD: begin
        // bin address is back on the read port; data lands for EXEC
        state_next = kbib_pkg::S_EXEC;
      end
      kbib_pkg::S_EXEC: begin
        if (!stat.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = kbib_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kbib_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/kbib_dpath.sv
// Datapath: bin count/fill memory, base memory, match store, layout adder and result register.
// Depends on kbib_pkg.
module kbib_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  kbib_pkg::ctrl_cmd_t               cmd,
  output kbib_pkg::ctrl_stat_t              stat,
  input  logic [kbib_pkg::IN_DATA_W-1:0]    in_data,
  input  logic [kbib_pkg::CMD_W-1:0]        in_user,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kbib_pkg::OUT_DATA_W-1:0]   out_data,
  output logic [kbib_pkg::STATUS_W-1:0]     out_user
);

  localparam int KB = kbib_pkg::KMER_BITS;
  localparam int SA = kbib_pkg::STORE_ADDR_BITS;
  localparam int CW = kbib_pkg::COUNT_W;
  localparam int OB = kbib_pkg::OFFSET_BITS;
  localparam logic [CW-1:0] STORE_FULL = {1'b1, {SA{1'b0}}};

  // memories
  logic [2*CW-1:0] cf_mem    [kbib_pkg::NUM_BINS];   // {fill, count}
  logic [SA-1:0]   base_mem  [kbib_pkg::NUM_BINS];
  logic [OB-1:0]   store_mem [kbib_pkg::STORE_SIZE];
  logic [2*CW-1:0] cf_q;
  logic [SA-1:0]   base_q;
  logic [OB-1:0]   store_q;

  // latched item
  kbib_pkg::cmd_t              cmd_q;
  logic [KB-1:0]               bin_q;
  logic [OB-1:0]               offset_q;
  logic [kbib_pkg::ENTRY_W-1:0] idx_q;

  // sweep and layout
  logic [KB:0]   sweep;
  logic          lay_vld;
  logic [KB-1:0] lay_addr;
  logic [CW-1:0] sum;
  logic          layout_done;
  logic [CW-1:0] total;

  // input decode
  logic [kbib_pkg::KMER_ID_W-1:0] in_kmer;
  logic [KB-1:0]                  in_bin;
  logic [kbib_pkg::ENTRY_W-1:0]   in_idx;
  logic [OB-1:0]                  in_offset;

  assign in_kmer   = in_data[kbib_pkg::ID_LSB +: kbib_pkg::KMER_ID_W];
  assign in_bin    = KB'(in_kmer);
  assign in_idx    = in_data[kbib_pkg::IDX_LSB +: kbib_pkg::ENTRY_W];
  assign in_offset = OB'(in_data[kbib_pkg::OFF_LSB +: kbib_pkg::OFFSET_W]);

  // read/write addresses
  logic [KB-1:0]     rd_addr;
  logic [SA-1:0]     st_raddr;
  logic [KB-1:0]     cf_waddr;
  logic [2*CW-1:0]   cf_wdata;
  logic              cf_we;

  assign rd_addr  = cmd.accept ? in_bin : (cmd.layout ? sweep[KB-1:0] : bin_q);
  assign st_raddr = SA'(cmd.accept ? in_idx : idx_q);

  // execute logic
  logic [CW-1:0]  cnt, fill, cnt_new, fill_new, slot_sum;
  logic [SA-1:0]  slot;
  logic           cf_we_x, st_we_x, total_inc;
  kbib_pkg::status_t res_status;
  logic [CW-1:0]  res_count;
  logic [SA-1:0]  res_base;
  logic [OB-1:0]  res_value;

  assign cnt      = cf_q[CW-1:0];
  assign fill     = cf_q[2*CW-1:CW];
  assign slot_sum = CW'(base_q) + fill;
  assign slot     = slot_sum[SA-1:0];

  always_comb begin
    res_status = kbib_pkg::ST_OK;
    res_count  = cnt;
    res_base   = '0;
    res_value  = '0;
    cnt_new    = cnt;
    fill_new   = fill;
    cf_we_x    = 1'b0;
    st_we_x    = 1'b0;
    total_inc  = 1'b0;
    case (cmd_q)
      kbib_pkg::CMD_COUNT: begin
        if (layout_done) begin
          res_status = kbib_pkg::ST_COUNT_LATE;
        end else if (total == STORE_FULL) begin
          res_status = kbib_pkg::ST_OVERFLOW;
        end else begin
          cnt_new   = cnt + CW'(1);
          res_count = cnt_new;
          cf_we_x   = 1'b1;
          total_inc = 1'b1;
        end
      end
      kbib_pkg::CMD_ADD: begin
        res_base = base_q;
        if (fill >= cnt) begin
          res_status = kbib_pkg::ST_BIN_FULL;
        end else begin
          st_we_x  = 1'b1;
          fill_new = fill + CW'(1);
          cf_we_x  = 1'b1;
        end
      end
      kbib_pkg::CMD_QUERY: begin
        if (!layout_done) res_status = kbib_pkg::ST_PENDING;
        else res_base = base_q;
      end
      kbib_pkg::CMD_READ: begin
        res_count = '0;
        if (!layout_done) begin
          res_status = kbib_pkg::ST_PENDING;
        end else if (kbib_pkg::CMP_W'(idx_q) >= kbib_pkg::CMP_W'(total)) begin
          res_status = kbib_pkg::ST_RANGE;
        end else begin
          res_value = store_q;
        end
      end
      default: begin
        res_status = kbib_pkg::ST_OK;
      end
    endcase
  end

  assign cf_we    = cmd.clear || (cmd.exec && cf_we_x);
  assign cf_waddr = cmd.clear ? sweep[KB-1:0] : bin_q;
  assign cf_wdata = cmd.clear ? '0 : {fill_new, cnt_new};

  always_ff @(posedge clk) begin
    if (cf_we) cf_mem[cf_waddr] <= cf_wdata;
    cf_q <= cf_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (lay_vld) base_mem[lay_addr] <= sum[SA-1:0];
    base_q <= base_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && st_we_x) store_mem[slot] <= offset_q;
    store_q <= store_mem[st_raddr];
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q    <= kbib_pkg::cmd_t'(in_user);
      bin_q    <= in_bin;
      offset_q <= in_offset;
      idx_q    <= in_idx;
    end
  end

  // clear sweep, then layout sweep on the same counter
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep   <= '0;
      lay_vld <= 1'b0;
    end else begin
      if (cmd.clear) begin
        sweep <= stat.clear_last ? '0 : sweep + (KB+1)'(1);
      end else if (cmd.layout && !sweep[KB]) begin
        sweep <= sweep + (KB+1)'(1);
      end
      lay_vld <= cmd.layout && !sweep[KB];
    end
  end

  always_ff @(posedge clk) begin
    lay_addr <= sweep[KB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum         <= '0;
      layout_done <= 1'b0;
      total       <= '0;
    end else begin
      if (lay_vld) sum <= sum + cnt;
      if (stat.layout_last) layout_done <= 1'b1;
      if (cmd.exec && total_inc) total <= total + CW'(1);
    end
  end

  // result register
  logic [kbib_pkg::MCOUNT_W-1:0] out_count;
  logic [kbib_pkg::BASE_W-1:0]   out_base;
  logic [kbib_pkg::VALUE_W-1:0]  out_value;
  kbib_pkg::status_t             out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status <= res_status;
      out_count  <= kbib_pkg::MCOUNT_W'(res_count);
      out_base   <= kbib_pkg::BASE_W'(res_base);
      out_value  <= kbib_pkg::VALUE_W'(res_value);
    end
  end

  assign out_data = {{kbib_pkg::OUT_PAD_W{1'b0}}, out_value, out_base, out_count};
  assign out_user = out_status;

  // status to controller
  assign stat.clear_last  = (sweep[KB-1:0] == {KB{1'b1}});
  assign stat.layout_last = lay_vld && (lay_addr == {KB{1'b1}});
  assign stat.layout_done = layout_done;
  assign stat.in_is_add   = (in_user == kbib_pkg::CMD_ADD);
  assign stat.out_busy    = out_valid && !out_ready;

endmodule

FILE: design/kmer_bucket_index_builder_top.sv
// Top level of the k-mer bucket index builder (two-pass counting sort index).
// Depends on kbib_pkg, kbib_ctrl and kbib_dpath.
//
//  channel   dir   signals                     word contents
//  --------  ----  --------------------------  ----------------------------------------
//  s_axis    in    tvalid tready tdata tuser   command word: opcode in tuser, operands
//  m_axis    out   tvalid tready tdata tuser   result word: status in tuser, values
//
// Flow: each command word is accepted, then executed before the next word is taken;
//   the single read port of the per-bin count/fill memory sets this read-modify-write order.
// The first add command runs the layout pass, one bin per cycle, and then re-reads its
//   bin before that add executes.
// Reset: synchronous, active high; afterwards a clearing pass zeroes count/fill,
//   one bin per cycle, with s_axis_tready low.
// Stalls: one finished result waits in the output register while the next word is
//   accepted; execution holds only if that register is still full.
module kmer_bucket_index_builder_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // kmer_id [11:0], genome_offset [43:12], entry_index [59:44], zero [63:60]
  input  logic [kbib_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // command [1:0]
  input  logic [kbib_pkg::CMD_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // match_count [16:0], base_index [32:17], entry_value [64:33], zero [71:65]
  output logic [kbib_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status [2:0]
  output logic [kbib_pkg::STATUS_W-1:0]     m_axis_tuser
);

  kbib_pkg::ctrl_cmd_t  ctrl_cmd;
  kbib_pkg::ctrl_stat_t ctrl_stat;

  // sequencer: clear sweep, accept, layout pass, execute
  kbib_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (ctrl_stat),
    .cmd      (ctrl_cmd)
  );

  // memories, prefix-sum adder and result register
  kbib_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctrl_cmd),
    .stat      (ctrl_stat),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

FILE: design/kbib_checker.sv
// Port-level checks for the k-mer bucket index builder, bound to the top level.
// Depends on kbib_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kbib_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [kbib_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic [kbib_pkg::STATUS_W-1:0]     m_axis_tuser
);

  logic                                              s_acc;
  logic                                              out_stall;
  logic [kbib_pkg::OUT_DATA_W+kbib_pkg::STATUS_W-1:0] out_word;

  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tuser, m_axis_tdata};

  // held result stays put
  `ASSERT_CLK(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_word), "held result moved")

  // reset starts the clearing pass with nothing pending
  `ASSERT_ALWAYS(a_reset_clear, rst |=> !s_axis_tready && !m_axis_tvalid, "busy after reset")

  // one word at a time: ready drops after an accept
  `ASSERT_CLK(a_one_at_a_time, s_acc |=> !s_axis_tready, "accepted back to back")

  // a new result only comes out of an execute cycle, never while idle
  `ASSERT_CLK(a_result_source, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "no execute")

  // status codes stay within the defined set
  `ASSERT_CLK(a_status_legal, m_axis_tvalid |-> m_axis_tuser <= kbib_pkg::ST_RANGE, "bad status")

endmodule

bind kmer_bucket_index_builder_top kbib_checker u_kbib_checker (.*);
